/* hw/rtl/capacitive_touch_baseline_detector_macros.svh */
// Assertion helpers, clocked on clk and held off during reset.
`ifndef CAPACITIVE_TOUCH_BASELINE_DETECTOR_MACROS_SVH
`define CAPACITIVE_TOUCH_BASELINE_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define CTBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctbd assertion failed");

// Next-cycle implication.
`define CTBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctbd assertion failed");

`endif

/* hw/rtl/ctbd_pkg.sv */
package ctbd_pkg;

  localparam int ELECTRODES_DEF  = 12;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int ELEC_W    = 4;
  localparam int NOW_W     = 32;
  localparam int THR_W     = 10;
  localparam int COOL_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS     = 1'd1;

  localparam logic [THR_W-1:0]  THR_RESET  = 10'd3;
  localparam logic [COOL_W-1:0] COOL_RESET = 16'd1000;

endpackage

/* hw/rtl/ctbd_in_if.sv */
interface ctbd_in_if #(
  parameter int SAMPLE_BITS = ctbd_pkg::SAMPLE_BITS_DEF
) ();
  logic                            valid;
  logic                            ready;
  logic [ctbd_pkg::ELEC_W-1:0]     electrode;
  logic [SAMPLE_BITS-1:0]          sample;
  logic [ctbd_pkg::NOW_W-1:0]      now_ms;

  modport source (output valid, electrode, sample, now_ms, input ready);
  modport sink   (input valid, electrode, sample, now_ms, output ready);
endinterface

/* hw/rtl/ctbd_out_if.sv */
interface ctbd_out_if ();
  logic                        valid;
  logic                        ready;
  logic                        touch_event;
  logic [ctbd_pkg::ELEC_W-1:0] touch_electrode;
  logic                        led_off;

  modport source (output valid, touch_event, touch_electrode, led_off, input ready);
  modport sink   (input valid, touch_event, touch_electrode, led_off, output ready);
endinterface

/* hw/rtl/ctbd_bl_ram.sv */
// Baseline store: one write port, one read port, registered read data.
module ctbd_bl_ram #(
  parameter int DEPTH = ctbd_pkg::ELECTRODES_DEF,
  parameter int AW    = 4,
  parameter int DW    = ctbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/capacitive_touch_baseline_detector.sv */
// Pipeline: a word is accepted and its baseline read is issued at the same edge; the
//   word then waits in s1 and moves to the output register when that register is
//   empty or being taken by the sink.
// Throughput: 1 word per cycle while the sink keeps ready high, set by the baseline
//   read-modify-write with one-deep forwarding from the write-back to the next read.
// Reset (rst_n, synchronous): clears pipeline valids, calibration, arm, indicator,
//   last touch time and the registers to their defaults; baselines are rewritten
//   by the first scan and need no clearing pass.
`include "capacitive_touch_baseline_detector_macros.svh"

module capacitive_touch_baseline_detector #(
  parameter int ELECTRODES  = ctbd_pkg::ELECTRODES_DEF,
  parameter int SAMPLE_BITS = ctbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ctbd_in_if.sink                          in_ch,
  ctbd_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ctbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctbd_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (ELECTRODES > 1) ? $clog2(ELECTRODES) : 1;
  localparam int CMP_W = (SAMPLE_BITS > ctbd_pkg::THR_W) ? SAMPLE_BITS : ctbd_pkg::THR_W;
  localparam int ACC_W = SAMPLE_BITS + 3;
  localparam int EW    = ctbd_pkg::ELEC_W;
  localparam logic [EW:0]   ELEC_LIM  = (EW+1)'(ELECTRODES);
  localparam logic [EW-1:0] ELEC_LAST = EW'(ELECTRODES - 1);
  localparam logic [EW-1:0] ELEC_FIRST = '0;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [ctbd_pkg::THR_W-1:0]  thr_r;
  logic [ctbd_pkg::COOL_W-1:0] cool_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ctbd_pkg::THR_RESET;
      cool_r <= ctbd_pkg::COOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ctbd_pkg::REG_TOUCH_THRESHOLD: thr_r  <= cfg_wdata[ctbd_pkg::THR_W-1:0];
        ctbd_pkg::REG_COOLDOWN_MS:     cool_r <= cfg_wdata[ctbd_pkg::COOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake. s1 holds the accepted word while its baseline comes
  // out of the RAM; the output register parts s1 from the sink.
  // ---------------------------------------------------------------
  logic s1_v_r;
  logic out_v_r;
  logic s1_fire;
  logic in_acc;

  assign s1_fire     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // s1 payload
  logic [EW-1:0]             s1_e_r;
  logic [SAMPLE_BITS-1:0]    s1_s_r;
  logic [ctbd_pkg::NOW_W-1:0] s1_now_r;

  // forwarding of the baseline written back in the cycle the read was issued
  logic                   fwd_hit_r;
  logic [SAMPLE_BITS-1:0] fwd_data_r;

  // control state
  logic                        cal_r;
  logic                        armed_r;
  logic                        ind_r;
  logic [ctbd_pkg::NOW_W-1:0]  last_r;

  // ---------------------------------------------------------------
  // Baseline RAM
  // ---------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] ram_q;
  logic                   wr_en;
  logic [SAMPLE_BITS-1:0] wr_data;

  ctbd_bl_ram #(
    .DEPTH (ELECTRODES),
    .AW    (IDX_W),
    .DW    (SAMPLE_BITS)
  ) u_bl_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_ch.electrode[IDX_W-1:0]),
    .rd_data (ram_q),
    .wr_en   (wr_en),
    .wr_addr (s1_e_r[IDX_W-1:0]),
    .wr_data (wr_data)
  );

  // ---------------------------------------------------------------
  // s1 compute: arm check, touch check, tracking filter
  // ---------------------------------------------------------------
  logic                        s1_inr;
  logic                        s1_first;
  logic                        armed_now;
  logic [ctbd_pkg::NOW_W-1:0]  since;
  logic [SAMPLE_BITS-1:0]      base;
  logic [SAMPLE_BITS-1:0]      diff;
  logic                        touch;
  logic [SAMPLE_BITS-1:0]      b_eff;
  logic [ACC_W-1:0]            acc;
  logic                        led;

  always_comb begin
    s1_inr    = {1'b0, s1_e_r} < ELEC_LIM;
    s1_first  = s1_e_r == ELEC_FIRST;
    since     = s1_now_r - last_r;
    armed_now = s1_first ? (since > ctbd_pkg::NOW_W'(cool_r)) : armed_r;
    base      = fwd_hit_r ? fwd_data_r : ram_q;
    diff      = base - s1_s_r;
    touch     = cal_r && s1_inr && armed_now && (base > s1_s_r) &&
                (CMP_W'(diff) > CMP_W'(thr_r));
    led       = cal_r && s1_inr && s1_first && armed_now && ind_r;
    b_eff     = touch ? s1_s_r : base;
    // (7*b + s) / 8
    acc       = {b_eff, 3'b000} - ACC_W'(b_eff) + ACC_W'(s1_s_r);
    wr_en     = s1_fire && s1_inr;
    wr_data   = cal_r ? acc[ACC_W-1:3] : s1_s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_e_r     <= in_ch.electrode;
      s1_s_r     <= in_ch.sample;
      s1_now_r   <= in_ch.now_ms;
      fwd_hit_r  <= wr_en && (s1_e_r == in_ch.electrode);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r   <= 1'b0;
      armed_r <= 1'b0;
      ind_r   <= 1'b0;
      last_r  <= '0;
    end else if (s1_fire && s1_inr) begin
      if (!cal_r) begin
        if (s1_e_r == ELEC_LAST) begin
          cal_r <= 1'b1;
        end
      end else begin
        armed_r <= armed_now && !touch;
        if (touch) begin
          ind_r  <= 1'b1;
          last_r <= s1_now_r;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic          out_te_r;
  logic [EW-1:0] out_el_r;
  logic          out_led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_te_r  <= touch;
      out_el_r  <= touch ? s1_e_r : '0;
      out_led_r <= led;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.touch_event     = out_te_r;
  assign out_ch.touch_electrode = out_el_r;
  assign out_ch.led_off         = out_led_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `CTBD_ASSERT_NEXT(a_touch_disarms, clk, rst_n, s1_fire && touch, !armed_r && ind_r)
  `CTBD_ASSERT_NEXT(a_cal_quiet, clk, rst_n, s1_fire && !cal_r,
                    !out_ch.touch_event && !out_ch.led_off)
  `CTBD_ASSERT_NOW(a_no_event_no_index, clk, rst_n, out_ch.valid && !out_ch.touch_event,
                   out_ch.touch_electrode == '0)
  `CTBD_ASSERT_NOW(a_event_in_range, clk, rst_n, out_ch.valid && out_ch.touch_event,
                   {1'b0, out_ch.touch_electrode} < ELEC_LIM)

endmodule

/* tb/ctbd_touch_checker.sv */
module ctbd_touch_checker
  import ctbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ctbd_in_if                   in_ch,
  ctbd_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   pending
);

  localparam int NELEC = ELECTRODES_DEF;
  localparam int SBITS = SAMPLE_BITS_DEF;

  typedef struct packed {
    logic              touch;
    logic [ELEC_W-1:0] elec;
    logic              led_off;
  } touch_report_t;

  touch_report_t    reports_due[$];
  logic [SBITS-1:0] baseline [NELEC];
  logic             calibrated;
  logic             indicator_on;
  logic             scan_armed;
  logic [NOW_W-1:0] last_touch_ms;
  logic [THR_W-1:0] threshold;
  logic [COOL_W-1:0] cooldown;
  int               mismatches = 0;

  // Advances the detector state by one word and returns the report it owes.
  function automatic touch_report_t track_sample(logic [ELEC_W-1:0] e, logic [SBITS-1:0] s,
                                                 logic [NOW_W-1:0] now);
    touch_report_t    r;
    logic [SBITS-1:0] b;
    logic [NOW_W-1:0] gap;
    logic [SBITS+3:0] mix;
    r = '0;
    if (e >= NELEC) return r;
    if (!calibrated) begin
      baseline[e] = s;
      if (e == NELEC - 1) calibrated = 1'b1;
      return r;
    end
    if (e == 0) begin
      gap = now - last_touch_ms;
      scan_armed = gap > cooldown;
      r.led_off = scan_armed && indicator_on;
    end
    b = baseline[e];
    if (scan_armed && b > s && (b - s) > threshold) begin
      r.touch       = 1'b1;
      r.elec        = e;
      last_touch_ms = now;
      indicator_on  = 1'b1;
      scan_armed    = 1'b0;
      b             = s;
    end
    mix = ({4'd0, b} * (SBITS+4)'(7) + {4'd0, s}) >> 3;
    baseline[e] = mix[SBITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : track_and_compare
    touch_report_t want;
    if (!rst_n) begin
      reports_due.delete();
      calibrated    = 1'b0;
      indicator_on  = 1'b0;
      scan_armed    = 1'b0;
      last_touch_ms = '0;
      threshold     = THR_RESET;
      cooldown      = COOL_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOUCH_THRESHOLD: threshold = cfg_wdata[THR_W-1:0];
          REG_COOLDOWN_MS:     cooldown  = cfg_wdata[COOL_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        reports_due.push_back(track_sample(in_ch.electrode, in_ch.sample, in_ch.now_ms));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual touch=%0b elec=%0d led_off=%0b",
                   $time, out_ch.touch_event, out_ch.touch_electrode, out_ch.led_off);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (out_ch.touch_event !== want.touch) begin
            $display("%0t: touch_event expected %0b actual %0b",
                     $time, want.touch, out_ch.touch_event);
            mismatches++;
          end
          if (out_ch.touch_electrode !== want.elec) begin
            $display("%0t: touch_electrode expected %0d actual %0d",
                     $time, want.elec, out_ch.touch_electrode);
            mismatches++;
          end
          if (out_ch.led_off !== want.led_off) begin
            $display("%0t: led_off expected %0b actual %0b",
                     $time, want.led_off, out_ch.led_off);
            mismatches++;
          end
        end
      end
    end
    errors  <= mismatches;
    pending <= reports_due.size();
  end

endmodule

/* tb/tb_capacitive_touch_baseline_detector.sv */
module tb_capacitive_touch_baseline_detector;
  import ctbd_pkg::*;

  localparam int NELEC = ELECTRODES_DEF;
  localparam int SBITS = SAMPLE_BITS_DEF;
  localparam int PHASE_WORDS = 170;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ctbd_in_if  in_ch ();
  ctbd_out_if out_ch ();

  int errors;
  int pending;

  // idle_on gates both the sender gaps and the receiver stalls
  logic             idle_on;
  int               stall_left = 0;
  int               words_sent = 0;
  logic [NOW_W-1:0] now_ms_cur;
  int               cool_cur;
  int               level [NELEC];

  capacitive_touch_baseline_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ctbd_touch_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: stalls come in bursts of random length while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      out_ch.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 11);
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= 1'b1;
    end
  end

  // Offers one word and returns at the edge that accepts it. Called at a
  // rising edge; valid stays high into the next word unless a gap is taken.
  task automatic send_word(input int e, input int s, input logic [NOW_W-1:0] now);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.electrode <= e[ELEC_W-1:0];
    in_ch.sample    <= s[SBITS-1:0];
    in_ch.now_ms    <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (e < NELEC) words_sent++;
  endtask

  // Drop valid and wait until every owed report has been checked.
  // pending is registered, so the task lets it update before it is trusted.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int thr, input int cool);
    write_reg(REG_TOUCH_THRESHOLD, thr);
    write_reg(REG_COOLDOWN_MS, cool);
    cool_cur = cool;
  endtask

  // Mostly whole scans 0..last, each with up to one chosen electrode pressed and rare
  // extra presses, some cut short, plus stray words (random index, sample and time).
  task automatic run_touch_traffic(input int words);
    int target;
    int touch_e;
    int stop_e;
    int v;
    target = words_sent + words;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word($urandom_range(0, 15), $urandom_range(0, 1023), $urandom());
      end else begin
        // time since the last scan: mostly around the cooldown, at times a wild jump
        case ($urandom_range(0, 7))
          0:       now_ms_cur = now_ms_cur + $urandom();
          1:       now_ms_cur = now_ms_cur + cool_cur;
          2:       now_ms_cur = now_ms_cur + cool_cur + 1;
          default: now_ms_cur = now_ms_cur + $urandom_range(0, 2 * cool_cur + 4);
        endcase
        if ($urandom_range(0, 7) == 0) begin
          foreach (level[i]) begin
            case ($urandom_range(0, 5))
              0:       level[i] = 0;
              1:       level[i] = 1023;
              default: level[i] = $urandom_range(0, 1023);
            endcase
          end
        end
        touch_e = $urandom_range(0, NELEC + 3);
        stop_e  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NELEC - 1) : NELEC;
        for (int e = 0; e < stop_e; e++) begin
          v = level[e] + int'($urandom_range(0, 6)) - 3;
          // a pressed electrode reads low; a second press tests the disarm
          if (e == touch_e || $urandom_range(0, 15) == 0) begin
            v = v - int'($urandom_range(0, level[e] + 8));
          end
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
          if ($urandom_range(0, 15) == 0) now_ms_cur = now_ms_cur + 1;
          send_word(e, v, now_ms_cur);
        end
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    idle_on         <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.electrode <= '0;
    in_ch.sample    <= '0;
    in_ch.now_ms    <= '0;
    cool_cur        = COOL_RESET;
    foreach (level[i]) level[i] = $urandom_range(0, 1023);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Calibration scan, reset register values in force. A stray index and a
    // repeated electrode ride along; every baseline is written before the last.
    send_word(15, 1023, '1);
    send_word(0, 1023, 0);
    send_word(1, 0, 0);
    for (int e = 2; e < NELEC - 1; e++) send_word(e, 512, 0);
    send_word(3, 700, 0);
    send_word(NELEC - 1, 1023, 0);

    // gap equal to the cooldown: not armed, out-of-order electrode first
    send_word(5, 0, 32'd1000);
    send_word(0, 0, 32'd1000);
    // one past the cooldown: full-scale drop on electrode 0 touches, the rest
    // of the scan stays disarmed
    send_word(0, 0, 32'd1001);
    send_word(1, 0, 32'd1001);
    send_word(0, 512, 32'd1500);
    // top of the time range: armed again, led_off once a touch has happened
    send_word(0, 300, '1);
    send_word(2, 0, '1);
    send_word(NELEC - 1, 1023, '1);
    send_word(NELEC, 0, 0);
    // time wrapped past zero, small unsigned difference: not armed
    send_word(0, 0, 32'd5);
    now_ms_cur = 32'd5;

    idle_on <= 1'b1;
    run_touch_traffic(PHASE_WORDS);
    wait_idle();

    // extremes of both registers, then a few realistic settings
    apply_setting(0, 0);
    run_touch_traffic(PHASE_WORDS);
    wait_idle();
    apply_setting(1023, 65535);
    run_touch_traffic(PHASE_WORDS / 2);
    wait_idle();
    apply_setting(0, 65535);
    run_touch_traffic(PHASE_WORDS / 2);
    wait_idle();
    apply_setting($urandom_range(1, 40), $urandom_range(0, 2000));
    run_touch_traffic(PHASE_WORDS);
    wait_idle();
    apply_setting($urandom_range(0, 1023), $urandom_range(0, 65535));
    run_touch_traffic(PHASE_WORDS / 2);
    wait_idle();

    // last stretch at full rate
    idle_on <= 1'b0;
    apply_setting($urandom_range(2, 20), $urandom_range(0, 500));
    run_touch_traffic(PHASE_WORDS);
    wait_idle();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("capacitive_touch_baseline_detector: match");
    end else begin
      $display("capacitive_touch_baseline_detector: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("capacitive_touch_baseline_detector: mismatch");
    $finish;
  end

endmodule
